FILE: hw/rtl/wfr_pkg.sv
// shared constants and types of the wiegand frame receiver
package wfr_pkg;

  // capture buffer size in bytes, 1 to 8
  localparam int BUFFER_BYTES = 8;
  localparam int CAP_BITS = (BUFFER_BYTES * 8 > 64) ? 64 : BUFFER_BYTES * 8;
  localparam int CNT_W = $clog2(CAP_BITS + 1);
  localparam int NIB_MAX = (CAP_BITS + 3) / 4;
  localparam int NIB_W = $clog2(NIB_MAX + 1);
  localparam int SR_W = 4 * NIB_MAX;

  localparam int TIMEOUT_W = 16;
  localparam int ID_W = 8;
  localparam int FBITS_W = 7;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam int M_DATA_W = 24;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd25;
  localparam logic [ID_W-1:0] READER_ID_RESET = 8'd0;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_READER_ID = 8'd1;

  // frame handed from capture to serializer
  typedef struct packed {
    logic [CAP_BITS-1:0] bits;
    logic [CNT_W-1:0] count;
  } frame_t;

endpackage

FILE: hw/rtl/wfr_capture.sv
// edge detection, bit buffer, idle timer and flush decision
module wfr_capture (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  logic d0_level,
  input  logic d1_level,
  input  logic ms_tick,
  input  logic [wfr_pkg::TIMEOUT_W-1:0] timeout,
  output logic flush,
  output wfr_pkg::frame_t frame
);

  logic [1:0] prev_levels, prev_levels_next;
  logic [wfr_pkg::CAP_BITS-1:0] bit_buffer, bit_buffer_next;
  logic [wfr_pkg::CNT_W-1:0] bit_count, bit_count_next;
  logic frame_pending, frame_pending_next;
  logic [wfr_pkg::TIMEOUT_W-1:0] idle_ms, idle_ms_next;

  always_comb begin
    logic [wfr_pkg::CAP_BITS-1:0] buf_v;
    logic [wfr_pkg::CNT_W-1:0] cnt_v;
    logic pend_v;
    logic [wfr_pkg::TIMEOUT_W-1:0] idle_v;
    buf_v = bit_buffer;
    cnt_v = bit_count;
    pend_v = frame_pending;
    idle_v = idle_ms;
    // tick first, saturating
    if (ms_tick && idle_v != '1) begin
      idle_v = idle_v + 1'b1;
    end
    // line 0 falling edge appends a zero
    if (prev_levels[0] && !d0_level &&
        cnt_v < wfr_pkg::CNT_W'(wfr_pkg::CAP_BITS)) begin
      buf_v = {buf_v[wfr_pkg::CAP_BITS-2:0], 1'b0};
      cnt_v = cnt_v + 1'b1;
      pend_v = 1'b1;
      idle_v = '0;
    end
    // line 1 falling edge appends a one
    if (prev_levels[1] && !d1_level &&
        cnt_v < wfr_pkg::CNT_W'(wfr_pkg::CAP_BITS)) begin
      buf_v = {buf_v[wfr_pkg::CAP_BITS-2:0], 1'b1};
      cnt_v = cnt_v + 1'b1;
      pend_v = 1'b1;
      idle_v = '0;
    end
    flush = pend_v && (idle_v > timeout) && (cnt_v != '0);
    frame.bits = buf_v;
    frame.count = cnt_v;
    prev_levels_next = {d1_level, d0_level};
    if (flush) begin
      bit_buffer_next = '0;
      bit_count_next = '0;
      frame_pending_next = 1'b0;
      idle_ms_next = '0;
    end else begin
      bit_buffer_next = buf_v;
      bit_count_next = cnt_v;
      frame_pending_next = pend_v;
      idle_ms_next = idle_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_levels <= 2'b11;
      bit_buffer <= '0;
      bit_count <= '0;
      frame_pending <= 1'b0;
      idle_ms <= '0;
    end else if (accept) begin
      prev_levels <= prev_levels_next;
      bit_buffer <= bit_buffer_next;
      bit_count <= bit_count_next;
      frame_pending <= frame_pending_next;
      idle_ms <= idle_ms_next;
    end
  end

endmodule

FILE: hw/rtl/wfr_serializer.sv
// nibble serializer around one shared shift-by-four unit
module wfr_serializer (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  wfr_pkg::frame_t frame,
  input  logic [wfr_pkg::ID_W-1:0] reader_id,
  output logic idle,
  output logic m_tvalid,
  input  logic m_tready,
  output logic [wfr_pkg::M_DATA_W-1:0] m_tdata,
  output logic m_tlast
);

  typedef enum logic [2:0] {
    SER_IDLE  = 3'b001,
    SER_ALIGN = 3'b010,
    SER_EMIT  = 3'b100
  } ser_state_t;

  ser_state_t state, state_next;
  logic [wfr_pkg::SR_W-1:0] sr, sr_next;
  logic [wfr_pkg::NIB_W-1:0] pad, pad_next;
  logic [wfr_pkg::NIB_W-1:0] remaining, remaining_next;
  logic [wfr_pkg::CNT_W-1:0] count, count_next;
  logic [wfr_pkg::CNT_W:0] count_rnd;
  logic [wfr_pkg::NIB_W-1:0] nnib;
  logic [wfr_pkg::SR_W-1:0] sr_shl;
  logic out_free;
  logic emit;

  assign count_rnd = {1'b0, frame.count} + (wfr_pkg::CNT_W+1)'(3);
  assign nnib = wfr_pkg::NIB_W'(count_rnd >> 2);
  // the shared unit
  assign sr_shl = {sr[wfr_pkg::SR_W-5:0], 4'b0000};
  assign out_free = !m_tvalid || m_tready;
  assign emit = (state == SER_EMIT) && out_free;
  assign idle = (state == SER_IDLE);

  always_comb begin
    state_next = state;
    sr_next = sr;
    pad_next = pad;
    remaining_next = remaining;
    count_next = count;
    case (state)
      SER_IDLE: begin
        if (load) begin
          sr_next = wfr_pkg::SR_W'(frame.bits);
          count_next = frame.count;
          remaining_next = nnib;
          pad_next = wfr_pkg::NIB_W'(wfr_pkg::NIB_MAX) - nnib;
          if (wfr_pkg::NIB_W'(wfr_pkg::NIB_MAX) == nnib) begin
            state_next = SER_EMIT;
          end else begin
            state_next = SER_ALIGN;
          end
        end
      end
      SER_ALIGN: begin
        // move the top digit of the frame to the top of the register
        sr_next = sr_shl;
        pad_next = pad - 1'b1;
        if (pad == wfr_pkg::NIB_W'(1)) begin
          state_next = SER_EMIT;
        end
      end
      SER_EMIT: begin
        if (out_free) begin
          sr_next = sr_shl;
          remaining_next = remaining - 1'b1;
          if (remaining == wfr_pkg::NIB_W'(1)) begin
            state_next = SER_IDLE;
          end
        end
      end
      default: begin
        state_next = SER_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SER_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sr <= sr_next;
    pad <= pad_next;
    remaining <= remaining_next;
    count <= count_next;
    if (emit) begin
      m_tdata <= {5'b00000, sr[wfr_pkg::SR_W-1 -: 4],
                  wfr_pkg::FBITS_W'(count), reader_id};
      m_tlast <= (remaining == wfr_pkg::NIB_W'(1));
    end
  end

endmodule

FILE: hw/rtl/wiegand_frame_receiver_core.sv
// top level of the wiegand frame receiver
// sequence: the sample that closes a frame loads it; the serializer starts in the next cycle,
//   aligns a short frame in the shift unit, then emits one digit a cycle while the output is free
// throughput: one sample per cycle while no frame drains; during a flush the
//   input waits on the single 4-bit shift unit through alignment and emission, plus output stalls
// reset: rst is synchronous, active high; lines read as idle high, frame empty,
//   timeout 25 ms, reader id 0
module wiegand_frame_receiver_core (
  input  logic clk,
  input  logic rst,
  // line samples
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [7:0] s_tdata,   // d0_level, d1_level, ms_tick, zero pad
  // hex digits of the frame
  output logic m_tvalid,
  input  logic m_tready,
  output logic [wfr_pkg::M_DATA_W-1:0] m_tdata, // source_id, frame_bits, nibble, zero pad
  output logic m_tlast,
  // register writes
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [wfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wfr_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [wfr_pkg::TIMEOUT_W-1:0] inter_bit_timeout_ms;
  logic [wfr_pkg::ID_W-1:0] reader_id;
  logic s_accept;
  logic flush;
  logic ser_idle;
  wfr_pkg::frame_t frame;

  // register writes are always taken; unknown indexes fall through
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      inter_bit_timeout_ms <= wfr_pkg::TIMEOUT_RESET;
      reader_id <= wfr_pkg::READER_ID_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        wfr_pkg::REG_TIMEOUT: inter_bit_timeout_ms <= cfg_data;
        wfr_pkg::REG_READER_ID: reader_id <= cfg_data[wfr_pkg::ID_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // samples stall only while the serializer drains a frame
  assign s_tready = ser_idle;
  assign s_accept = s_tvalid && s_tready;

  // edge capture and timeout check
  wfr_capture u_capture (
    .clk      (clk),
    .rst      (rst),
    .accept   (s_accept),
    .d0_level (s_tdata[0]),
    .d1_level (s_tdata[1]),
    .ms_tick  (s_tdata[2]),
    .timeout  (inter_bit_timeout_ms),
    .flush    (flush),
    .frame    (frame)
  );

  // the frame is loaded on the same request that completes it
  wfr_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .load      (s_accept && flush),
    .frame     (frame),
    .reader_id (reader_id),
    .idle      (ser_idle),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

FILE: tb/tb_wiegand_frame_receiver_core.sv
// self-checking testbench of the wiegand frame receiver core
`timescale 1ns / 100ps

module tb_wiegand_frame_receiver_core;

  localparam int LONG_HOLD = 400;        // long receiver hold-off, in cycles
  localparam int SETTLE_CYCLES = 48;     // covers alignment plus sixteen digits
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no request moving at all

  // one hex digit of an emitted frame
  typedef struct packed {
    logic [wfr_pkg::ID_W-1:0] source_id;
    logic [wfr_pkg::FBITS_W-1:0] frame_bits;
    logic [3:0] nibble;
    logic last;
  } digit_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [7:0] s_tdata;             // d0_level, d1_level, ms_tick, zero pad
  logic m_tvalid;
  logic m_tready;
  logic [wfr_pkg::M_DATA_W-1:0] m_tdata;    // source_id, frame_bits, nibble, zero pad
  logic m_tlast;
  logic cfg_valid;
  logic cfg_ready;
  logic [wfr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [wfr_pkg::CFG_DATA_W-1:0] cfg_data;

  wiegand_frame_receiver_core uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predicted receiver state and its register copies
  logic [wfr_pkg::TIMEOUT_W-1:0] timeout_ms;
  logic [wfr_pkg::ID_W-1:0] reader_id;
  logic [1:0] line_hist;           // {d1, d0} of the previous sample
  logic [63:0] held_bits;
  int held_count;
  bit frame_open;
  logic [15:0] idle_ms;

  digit_t pending_digits[$];       // digits still owed by the block
  int mismatch_cnt;
  int samples_sent;
  int quiet_cycles;
  bit src_idling;
  bit sink_idling;
  bit hold_req;
  bit hold_active;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_receiver();
    timeout_ms = wfr_pkg::TIMEOUT_RESET;
    reader_id = wfr_pkg::READER_ID_RESET;
    line_hist = 2'b11;
    held_bits = '0;
    held_count = 0;
    frame_open = 1'b0;
    idle_ms = '0;
  endfunction

  // a falling edge that finds the buffer full is dropped and keeps the idle time
  function automatic void capture_bit(input bit value);
    if (held_count < wfr_pkg::CAP_BITS) begin
      held_bits = {held_bits[62:0], value};
      held_count++;
      frame_open = 1'b1;
      idle_ms = '0;
    end
  endfunction

  // apply one line sample and queue the digits of a frame that it closes
  function automatic void predict_digits(input bit d0, input bit d1, input bit tick);
    int ndig;
    digit_t dig;
    if (tick && idle_ms != 16'hFFFF) idle_ms++;
    // line zero is looked at before line one
    if (line_hist[0] && !d0) capture_bit(1'b0);
    if (line_hist[1] && !d1) capture_bit(1'b1);
    line_hist = {d1, d0};
    if (frame_open && idle_ms > timeout_ms && held_count != 0) begin
      ndig = (held_count + 3) / 4;
      for (int k = 0; k < ndig; k++) begin
        dig.source_id = reader_id;
        dig.frame_bits = held_count[wfr_pkg::FBITS_W-1:0];
        dig.nibble = 4'((held_bits >> (4 * (ndig - 1 - k))) & 64'hF);
        dig.last = (k == ndig - 1);
        pending_digits.push_back(dig);
      end
      held_bits = '0;
      held_count = 0;
      frame_open = 1'b0;
      idle_ms = '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result side: ready pattern and digit checker
  // ---------------------------------------------------------------------------

  // the hold-off is counted here, apart from the sender
  initial begin : result_sink
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_active = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_active = 1'b0;
      end else if (sink_idling && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t error: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  // every digit taken off the bus is held against the oldest prediction
  always @(posedge clk) begin
    digit_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_digits.size() == 0) begin
        $display("%0t error: digit expected none actual %h last %b", $time, m_tdata, m_tlast);
        mismatch_cnt++;
      end else begin
        want = pending_digits.pop_front();
        check_field("source_id", int'(want.source_id),
                    int'(m_tdata[wfr_pkg::ID_W-1:0]));
        check_field("frame_bits", int'(want.frame_bits),
                    int'(m_tdata[wfr_pkg::ID_W+wfr_pkg::FBITS_W-1:wfr_pkg::ID_W]));
        check_field("nibble", int'(want.nibble),
                    int'(m_tdata[wfr_pkg::ID_W+wfr_pkg::FBITS_W+3:
                                 wfr_pkg::ID_W+wfr_pkg::FBITS_W]));
        check_field("last", int'(want.last), int'(m_tlast));
      end
    end
  end

  // ends a run that hangs: no sample, digit or register request for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t error: no progress, %0d digits outstanding", $time, pending_digits.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sample and register requests
  // ---------------------------------------------------------------------------

  function automatic bit tick_roll(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // called and returning at a falling edge; valid stays up for the next sample
  task automatic send_sample(input bit d0, input bit d1, input bit tick);
    if (src_idling && $urandom_range(0, 9) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, tick, d1, d0};
    do @(posedge clk); while (!s_tready);
    predict_digits(d0, d1, tick);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic source_idle();
    s_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  // sender pauses until every owed digit has come and the serializer is done
  task automatic drain();
    source_idle();
    while (pending_digits.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [wfr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wfr_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == wfr_pkg::REG_TIMEOUT)
      timeout_ms = data;
    else if (idx == wfr_pkg::REG_READER_ID)
      reader_id = data[wfr_pkg::ID_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // well-formed wiegand pulses: one line low for a few samples, then both high
  task automatic send_frame(input int nbits, input int tick_pct);
    bit b;
    for (int i = 0; i < nbits; i++) begin
      b = 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 3)) send_sample(b, !b, tick_roll(tick_pct));
      repeat ($urandom_range(1, 2)) send_sample(1'b1, 1'b1, tick_roll(tick_pct));
    end
  endtask

  // idle lines with ticks until the predictor sees the frame go out
  task automatic tick_until_flush();
    int guard;
    guard = 0;
    while (frame_open && guard < 400) begin
      send_sample(1'b1, 1'b1, $urandom_range(0, 3) != 0);
      guard++;
    end
  endtask

  // glitches, both lines low, lines stuck low
  task automatic send_noise(input int n);
    repeat (n) send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset settings: quiet lines give nothing, a short frame waits out 25 ms
  task automatic test_reset_settings();
    send_sample(1'b1, 1'b1, 1'b1);
    send_sample(1'b1, 1'b1, 1'b0);
    send_sample(1'b1, 1'b1, 1'b1);
    send_frame(3, 0);
    tick_until_flush();
  endtask

  // both lines fall in one sample: line zero first, then line one
  task automatic test_both_edges();
    drain();
    write_reg(wfr_pkg::REG_TIMEOUT, 16'h0000);
    write_reg(wfr_pkg::REG_READER_ID, 16'hFFFF);
    send_sample(1'b0, 1'b0, 1'b0);
    send_sample(1'b0, 1'b0, 1'b0);   // held low, no new edge
    send_sample(1'b1, 1'b1, 1'b1);   // first tick after the bits closes the frame
  endtask

  // zero timeout: a tick in the same sample as the bit does not close it
  task automatic test_zero_timeout();
    send_sample(1'b1, 1'b0, 1'b1);
    send_sample(1'b1, 1'b1, 1'b0);
    send_sample(1'b1, 1'b1, 1'b1);
  endtask

  // writes beyond the last register leave both registers alone
  task automatic test_unknown_register();
    drain();
    write_reg(8'd2, 16'h0005);
    write_reg(8'hFF, 16'hFFFF);
    send_frame(2, 0);
    send_sample(1'b1, 1'b1, 1'b1);
  endtask

  // buffer full: extra edges are dropped and keep the idle count running
  task automatic test_buffer_full();
    drain();
    write_reg(wfr_pkg::REG_TIMEOUT, 16'd3);
    write_reg(wfr_pkg::REG_READER_ID, 16'($urandom_range(0, 255)));
    // both lines fall together, two bits per pulse, past the capacity
    repeat (34) begin
      send_sample(1'b0, 1'b0, 1'b0);
      send_sample(1'b1, 1'b1, 1'b0);
    end
    send_sample(1'b1, 1'b1, 1'b1);
    send_sample(1'b1, 1'b1, 1'b1);
    send_sample(1'b1, 1'b0, 1'b1);   // dropped edge
    send_sample(1'b1, 1'b1, 1'b1);
    send_frame(2, 0);
    tick_until_flush();
  endtask

  // receiver holds off while a frame drains; the input has to stall
  task automatic test_backpressure();
    drain();
    write_reg(wfr_pkg::REG_TIMEOUT, 16'd0);
    hold_req = 1'b1;
    wait (hold_active);
    @(negedge clk);
    send_frame(6, 0);
    send_sample(1'b1, 1'b1, 1'b1);
    send_noise(8);
    send_frame(3, 0);
    tick_until_flush();
    wait (!hold_active);
    @(negedge clk);
    drain();
  endtask

  // random frames over several settings, with noise and broken frames
  task automatic test_random_traffic();
    logic [wfr_pkg::TIMEOUT_W-1:0] tmo_set [4] = '{16'd1, 16'd0, 16'd6, 16'd3};
    logic [wfr_pkg::ID_W-1:0] rid;
    int goal;
    int len;
    for (int s = 0; s < 4; s++) begin
      drain();
      rid = (s == 0) ? 8'h00 : (s == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      write_reg(wfr_pkg::REG_TIMEOUT, tmo_set[s]);
      write_reg(wfr_pkg::REG_READER_ID, {8'($urandom_range(0, 255)), rid});
      goal = samples_sent + 8;
      while (samples_sent < goal) begin
        if ($urandom_range(0, 9) == 0) begin
          send_noise($urandom_range(1, 6));
        end else begin
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 5);
          // mostly quiet frames; some tick often and get cut up
          send_frame(len, ($urandom_range(0, 4) == 0) ? 30 : 0);
          if ($urandom_range(0, 4) != 0) tick_until_flush();
        end
      end
    end
  endtask

  // largest timeout: idle ticks never pass it, a smaller one lets the frame out
  task automatic test_idle_saturation();
    drain();
    src_idling = 1'b0;
    sink_idling = 1'b0;
    write_reg(wfr_pkg::REG_TIMEOUT, 16'hFFFF);
    send_frame(2, 0);
    repeat (12) send_sample(1'b1, 1'b1, 1'b1);
    drain();
    // idle count is already past the new timeout, so the next step emits
    write_reg(wfr_pkg::REG_TIMEOUT, 16'd1);
    send_sample(1'b1, 1'b1, 1'b0);
    send_frame(1, 0);
    tick_until_flush();
    send_frame($urandom_range(1, 8), 10);
    tick_until_flush();
  endtask

  initial begin : run
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h03;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatch_cnt = 0;
    samples_sent = 0;
    quiet_cycles = 0;
    src_idling = 1'b1;
    sink_idling = 1'b1;
    hold_req = 1'b0;
    hold_active = 1'b0;
    clear_receiver();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_settings();
    test_both_edges();
    test_zero_timeout();
    test_unknown_register();
    test_buffer_full();
    test_backpressure();
    test_random_traffic();
    test_idle_saturation();

    drain();
    if (mismatch_cnt == 0 && pending_digits.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
